// ===== rtl/gvbm_pkg.sv =====
// gvbm_pkg: shared types and constants of the greedy voxel box merger
// depends on nothing
package gvbm_pkg;

  localparam int MASK_WORDS = 512;
  localparam int WORD_AW = 9;
  localparam int SIZE_W = 6;

  localparam logic FUNC_LOAD = 1'b0;
  localparam logic FUNC_FETCH = 1'b1;

  localparam logic [1:0] CFG_SIZE_X = 2'd0;
  localparam logic [1:0] CFG_SIZE_Y = 2'd1;
  localparam logic [1:0] CFG_SIZE_Z = 2'd2;

  typedef struct packed {
    logic        func;
    logic [8:0]  word_index;
    logic [63:0] mask_word;
  } cmd_t;

  typedef struct packed {
    logic       box_valid;
    logic [4:0] start_x;
    logic [4:0] start_y;
    logic [4:0] start_z;
    logic [5:0] len_x;
    logic [5:0] len_y;
    logic [5:0] len_z;
    logic       done_res;
  } res_t;

  typedef struct packed {
    logic               we;
    logic [WORD_AW-1:0] waddr;
    logic [63:0]        wdata;
    logic               re;
    logic [WORD_AW-1:0] raddr;
  } mem_req_t;

endpackage

// ===== rtl/greedy_voxel_box_merge_top.sv =====
// greedy_voxel_box_merge_top: top level of the greedy voxel box merger
// depends on gvbm_pkg, gvbm_ram, gvbm_addr, gvbm_ctrl
//
// a command transfers at a rising edge with start high and busy low.
// cmd.func load writes one 64-bit mask word in that cycle, restarts the
// scan, gives no result and leaves busy low. cmd.func fetch continues the
// z/y/x raster scan and gives exactly one result: a merged box, or
// done_res once the scan has ended (then in the cycle after the transfer).
// result_valid is high for one cycle with result; the receiver cannot
// stall, so it must take it then.
// each cell access goes through the two stage index unit and the single
// read port of the mask memory, in the states A1, A2, RD and USE. a fetch
// makes one such access per scanned cell, per cell checked while growing
// in y and z and per cell cleared, plus the setup states GZ0 and CL0 for a
// box; a full 32x32x32 box is the worst case.
// size writes on wr_en (index 0..2) while busy is low take effect at once
// and restart the scan. reset restores sizes of 32 and an empty scan;
// mask contents are undefined until loaded.
module greedy_voxel_box_merge_top #(
  parameter int MAX_DIM = 32
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  gvbm_pkg::cmd_t              cmd,
  output logic                        busy,
  input  logic                        wr_en,
  input  logic [1:0]                  wr_index,
  input  logic [gvbm_pkg::SIZE_W-1:0] wr_data,
  output logic                        result_valid,
  output gvbm_pkg::res_t              result
);
  import gvbm_pkg::*;

  localparam int CW = $clog2(MAX_DIM + 1);
  localparam int IW = (3 * CW > 16) ? 3 * CW : 16;

  mem_req_t mem_req;
  logic [63:0] mem_rdata;
  logic [IW-1:0] idx;
  logic [CW-1:0] ax, ay, az, sx, sy;

  gvbm_ram u_ram (
    .clk   (clk),
    .req   (mem_req),
    .rdata (mem_rdata)
  );

  gvbm_addr #(.CW(CW), .IW(IW)) u_addr (
    .clk (clk),
    .x   (ax),
    .y   (ay),
    .z   (az),
    .sx  (sx),
    .sy  (sy),
    .idx (idx)
  );

  gvbm_ctrl #(.MAX_DIM(MAX_DIM), .CW(CW), .IW(IW)) u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .cmd          (cmd),
    .wr_en        (wr_en),
    .wr_index     (wr_index),
    .wr_data      (wr_data),
    .busy         (busy),
    .result_valid (result_valid),
    .result       (result),
    .mem_req      (mem_req),
    .mem_rdata    (mem_rdata),
    .idx          (idx),
    .ax           (ax),
    .ay           (ay),
    .az           (az),
    .sx           (sx),
    .sy           (sy)
  );

endmodule

// ===== rtl/gvbm_ram.sv =====
// gvbm_ram: occupancy mask store, one write and one registered read port
// depends on gvbm_pkg
module gvbm_ram (
  input  logic               clk,
  input  gvbm_pkg::mem_req_t req,
  output logic [63:0]        rdata
);
  import gvbm_pkg::*;

  logic [63:0] mem [MASK_WORDS];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    if (req.re) begin
      rdata <= mem[req.raddr];
    end
  end

endmodule

// ===== rtl/gvbm_addr.sv =====
// gvbm_addr: two stage cell index unit, idx = x + sx*(y + sy*z)
// depends on nothing
module gvbm_addr #(
  parameter int CW = 6,
  parameter int IW = 18
) (
  input  logic          clk,
  input  logic [CW-1:0] x,
  input  logic [CW-1:0] y,
  input  logic [CW-1:0] z,
  input  logic [CW-1:0] sx,
  input  logic [CW-1:0] sy,
  output logic [IW-1:0] idx
);
  localparam int TW = 2 * CW;

  logic [TW-1:0] t;

  always_ff @(posedge clk) begin
    t   <= TW'(y) + TW'(sy) * TW'(z);
    idx <= IW'(x) + IW'(sx) * IW'(t);
  end

endmodule

// ===== rtl/gvbm_ctrl.sv =====
// gvbm_ctrl: scan, grow and clear sequencer with size registers
// depends on gvbm_pkg, drives gvbm_addr and gvbm_ram from the top level
module gvbm_ctrl #(
  parameter int MAX_DIM = 32,
  parameter int CW = 6,
  parameter int IW = 18
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  input  gvbm_pkg::cmd_t                   cmd,
  input  logic                             wr_en,
  input  logic [1:0]                       wr_index,
  input  logic [gvbm_pkg::SIZE_W-1:0]      wr_data,
  output logic                             busy,
  output logic                             result_valid,
  output gvbm_pkg::res_t                   result,
  output gvbm_pkg::mem_req_t               mem_req,
  input  logic [63:0]                      mem_rdata,
  input  logic [IW-1:0]                    idx,
  output logic [CW-1:0]                    ax,
  output logic [CW-1:0]                    ay,
  output logic [CW-1:0]                    az,
  output logic [CW-1:0]                    sx,
  output logic [CW-1:0]                    sy
);
  import gvbm_pkg::*;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_A1   = 3'd1;
  localparam logic [2:0] ST_A2   = 3'd2;
  localparam logic [2:0] ST_RD   = 3'd3;
  localparam logic [2:0] ST_USE  = 3'd4;
  localparam logic [2:0] ST_GZ0  = 3'd5;
  localparam logic [2:0] ST_CL0  = 3'd6;

  localparam logic [1:0] MODE_SCAN = 2'd0;
  localparam logic [1:0] MODE_GY   = 2'd1;
  localparam logic [1:0] MODE_GZ   = 2'd2;
  localparam logic [1:0] MODE_CLR  = 2'd3;

  localparam int CELL_LIMIT = MASK_WORDS * 64;

  localparam res_t RES_DONE = '{done_res: 1'b1, default: '0};

  logic [2:0] state;
  logic [1:0] mode;
  logic [SIZE_W-1:0] size_x, size_y, size_z;
  logic [CW-1:0] sz;
  logic [CW-1:0] scan_x, scan_y, scan_z, run_start;
  logic run_active, scan_finished;
  logic [CW-1:0] cur_x, cur_y, cur_z;
  logic [CW-1:0] bx, ex, by, bz, ey, ez;
  logic rd_ok;
  logic [5:0] bitpos;
  logic cell_set;

  logic s_commit, s_active, s_fin;
  logic [CW-1:0] s_bx, s_ex, s_run_start, s_nx, s_ny, s_nz;

  function automatic logic [CW-1:0] eff(input logic [SIZE_W-1:0] v);
    logic [CW-1:0] r;
    if (v == '0) begin
      r = CW'(1);
    end else if ({1'b0, v} > 7'(MAX_DIM)) begin
      r = CW'(MAX_DIM);
    end else begin
      r = CW'(v);
    end
    return r;
  endfunction

  assign sx = eff(size_x);
  assign sy = eff(size_y);
  assign sz = eff(size_z);
  assign ax = cur_x;
  assign ay = cur_y;
  assign az = cur_z;
  assign busy = (state != ST_IDLE);
  assign cell_set = rd_ok & mem_rdata[bitpos];

  always_comb begin
    s_commit = 1'b0;
    s_bx = run_start;
    s_ex = scan_x - CW'(1);
    s_run_start = run_start;
    s_active = run_active;
    s_nx = scan_x + CW'(1);
    s_ny = scan_y;
    s_nz = scan_z;
    s_fin = scan_finished;
    if (!cell_set) begin
      if (run_active) begin
        s_commit = 1'b1;
      end
    end else if (!run_active) begin
      s_active = 1'b1;
      s_run_start = scan_x;
      s_bx = scan_x;
    end
    if (scan_x + CW'(1) >= sx) begin
      if (cell_set) begin
        s_commit = 1'b1;
        s_ex = sx - CW'(1);
      end
      s_nx = '0;
      s_ny = scan_y + CW'(1);
      if (s_ny >= sy) begin
        s_ny = '0;
        s_nz = scan_z + CW'(1);
        if (s_nz >= sz) begin
          s_nz = '0;
          s_fin = 1'b1;
        end
      end
    end
    if (s_commit) begin
      s_active = 1'b0;
    end
  end

  always_comb begin
    mem_req.we = 1'b0;
    mem_req.waddr = idx[WORD_AW+5:6];
    mem_req.wdata = mem_rdata & ~(64'd1 << bitpos);
    mem_req.re = (state == ST_RD);
    mem_req.raddr = idx[WORD_AW+5:6];
    if (state == ST_IDLE && start && cmd.func == FUNC_LOAD) begin
      mem_req.we = 1'b1;
      mem_req.waddr = cmd.word_index;
      mem_req.wdata = cmd.mask_word;
    end else if (state == ST_USE && mode == MODE_CLR) begin
      mem_req.we = rd_ok;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      mode <= MODE_SCAN;
      size_x <= SIZE_W'(32);
      size_y <= SIZE_W'(32);
      size_z <= SIZE_W'(32);
      scan_x <= '0;
      scan_y <= '0;
      scan_z <= '0;
      run_active <= 1'b0;
      run_start <= '0;
      scan_finished <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      result_valid <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (wr_en) begin
            case (wr_index)
              CFG_SIZE_X: size_x <= wr_data;
              CFG_SIZE_Y: size_y <= wr_data;
              CFG_SIZE_Z: size_z <= wr_data;
              default: ;
            endcase
          end
          if ((wr_en && wr_index <= CFG_SIZE_Z) || (start && cmd.func == FUNC_LOAD)) begin
            scan_x <= '0;
            scan_y <= '0;
            scan_z <= '0;
            run_active <= 1'b0;
            run_start <= '0;
            scan_finished <= 1'b0;
          end
          if (start && cmd.func == FUNC_FETCH) begin
            if (scan_finished) begin
              result <= RES_DONE;
              result_valid <= 1'b1;
            end else begin
              cur_x <= scan_x;
              cur_y <= scan_y;
              cur_z <= scan_z;
              mode <= MODE_SCAN;
              state <= ST_A1;
            end
          end
        end
        ST_A1: state <= ST_A2;
        ST_A2: state <= ST_RD;
        ST_RD: begin
          rd_ok <= (idx < IW'(CELL_LIMIT));
          bitpos <= idx[5:0];
          state <= ST_USE;
        end
        ST_USE: begin
          case (mode)
            MODE_SCAN: begin
              scan_x <= s_nx;
              scan_y <= s_ny;
              scan_z <= s_nz;
              run_active <= s_active;
              run_start <= s_run_start;
              scan_finished <= s_fin;
              if (s_commit) begin
                bx <= s_bx;
                ex <= s_ex;
                by <= scan_y;
                bz <= scan_z;
                if (scan_y + CW'(1) < sy) begin
                  cur_x <= s_bx;
                  cur_y <= scan_y + CW'(1);
                  cur_z <= scan_z;
                  mode <= MODE_GY;
                  state <= ST_A1;
                end else begin
                  ey <= scan_y;
                  state <= ST_GZ0;
                end
              end else if (s_fin) begin
                result <= RES_DONE;
                result_valid <= 1'b1;
                state <= ST_IDLE;
              end else begin
                cur_x <= s_nx;
                cur_y <= s_ny;
                cur_z <= s_nz;
                state <= ST_A1;
              end
            end
            MODE_GY: begin
              if (!cell_set) begin
                ey <= cur_y - CW'(1);
                state <= ST_GZ0;
              end else if (cur_x != ex) begin
                cur_x <= cur_x + CW'(1);
                state <= ST_A1;
              end else if (cur_y + CW'(1) < sy) begin
                cur_y <= cur_y + CW'(1);
                cur_x <= bx;
                state <= ST_A1;
              end else begin
                ey <= cur_y;
                state <= ST_GZ0;
              end
            end
            MODE_GZ: begin
              if (!cell_set) begin
                ez <= cur_z - CW'(1);
                state <= ST_CL0;
              end else if (cur_x != ex) begin
                cur_x <= cur_x + CW'(1);
                state <= ST_A1;
              end else if (cur_y != ey) begin
                cur_y <= cur_y + CW'(1);
                cur_x <= bx;
                state <= ST_A1;
              end else if (cur_z + CW'(1) < sz) begin
                cur_z <= cur_z + CW'(1);
                cur_y <= by;
                cur_x <= bx;
                state <= ST_A1;
              end else begin
                ez <= cur_z;
                state <= ST_CL0;
              end
            end
            default: begin
              if (cur_x != ex) begin
                cur_x <= cur_x + CW'(1);
                state <= ST_A1;
              end else if (cur_y != ey) begin
                cur_y <= cur_y + CW'(1);
                cur_x <= bx;
                state <= ST_A1;
              end else if (cur_z != ez) begin
                cur_z <= cur_z + CW'(1);
                cur_y <= by;
                cur_x <= bx;
                state <= ST_A1;
              end else begin
                result.box_valid <= 1'b1;
                result.start_x <= 5'(bx);
                result.start_y <= 5'(by);
                result.start_z <= 5'(bz);
                result.len_x <= 6'(ex - bx + CW'(1));
                result.len_y <= 6'(ey - by + CW'(1));
                result.len_z <= 6'(ez - bz + CW'(1));
                result.done_res <= 1'b0;
                result_valid <= 1'b1;
                state <= ST_IDLE;
              end
            end
          endcase
        end
        ST_GZ0: begin
          if (bz + CW'(1) < sz) begin
            cur_x <= bx;
            cur_y <= by;
            cur_z <= bz + CW'(1);
            mode <= MODE_GZ;
            state <= ST_A1;
          end else begin
            ez <= bz;
            state <= ST_CL0;
          end
        end
        ST_CL0: begin
          cur_x <= bx;
          cur_y <= by;
          cur_z <= bz;
          mode <= MODE_CLR;
          state <= ST_A1;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_result_idle: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> state == ST_IDLE)
    else $error("result transfer outside idle");
  a_write_slot: assert property (@(posedge clk) disable iff (rst)
    mem_req.we |-> (state == ST_IDLE || (state == ST_USE && mode == MODE_CLR)))
    else $error("mask write in wrong state");
  a_fin_no_run: assert property (@(posedge clk) disable iff (rst)
    scan_finished |-> !run_active)
    else $error("open run after scan end");
  a_read_then_use: assert property (@(posedge clk) disable iff (rst)
    state == ST_RD |=> state == ST_USE)
    else $error("read not followed by use");
`endif

endmodule

// ===== dv/tb_greedy_voxel_box_merge_top.sv =====
// tb_greedy_voxel_box_merge_top: self-checking bench for the greedy voxel box merger
// depends on gvbm_pkg and greedy_voxel_box_merge_top; a scoreboard class predicts each
// fetch result from its own copy of the mask, sizes and scan state
module tb_greedy_voxel_box_merge_top;
  timeunit 1ns;
  timeprecision 1ps;
  import gvbm_pkg::*;

  class box_scoreboard;
    logic [63:0] cells[MASK_WORDS];
    int unsigned dim_x, dim_y, dim_z;
    int unsigned pos_x, pos_y, pos_z, run_x0;
    bit run_on, finished;
    res_t pending[$];
    int errors;

    function new();
      foreach (cells[i]) cells[i] = '0;
      dim_x = 32;
      dim_y = 32;
      dim_z = 32;
      errors = 0;
      restart();
    endfunction

    function void restart();
      pos_x = 0;
      pos_y = 0;
      pos_z = 0;
      run_on = 0;
      run_x0 = 0;
      finished = 0;
    endfunction

    function int unsigned clamp(int unsigned v);
      if (v == 0) return 1;
      if (v > 32) return 32;
      return v;
    endfunction

    function int unsigned cell_no(int unsigned x, int unsigned y, int unsigned z);
      return x + clamp(dim_x) * (y + clamp(dim_y) * z);
    endfunction

    function bit occupied(int unsigned x, int unsigned y, int unsigned z);
      int unsigned i;
      i = cell_no(x, y, z);
      if ((i >> 6) >= MASK_WORDS) return 0;
      return cells[i >> 6][i & 63];
    endfunction

    function void vacate(int unsigned x, int unsigned y, int unsigned z);
      int unsigned i;
      i = cell_no(x, y, z);
      if ((i >> 6) < MASK_WORDS) cells[i >> 6][i & 63] = 1'b0;
    endfunction

    function void set_size(logic [1:0] idx, logic [5:0] v);
      case (idx)
        CFG_SIZE_X: dim_x = v;
        CFG_SIZE_Y: dim_y = v;
        CFG_SIZE_Z: dim_z = v;
        default: return;
      endcase
      restart();
    endfunction

    function void note_cmd(cmd_t c);
      int unsigned sx, sy, sz, x, y, z, bx, ex, ey, ez, cx, cy, cz;
      bit hit, commit, full;
      res_t r;
      if (c.func == FUNC_LOAD) begin
        cells[c.word_index] = c.mask_word;
        restart();
        return;
      end
      sx = clamp(dim_x);
      sy = clamp(dim_y);
      sz = clamp(dim_z);
      r = '0;
      while (!finished) begin
        x = pos_x;
        y = pos_y;
        z = pos_z;
        hit = occupied(x, y, z);
        commit = 0;
        bx = run_x0;
        ex = 0;
        if (!hit) begin
          if (run_on) begin
            commit = 1;
            ex = x - 1;
          end
        end else if (!run_on) begin
          run_on = 1;
          run_x0 = x;
          bx = x;
        end
        if (x + 1 >= sx) begin
          if (hit) begin
            commit = 1;
            ex = sx - 1;
          end
          pos_x = 0;
          pos_y = y + 1;
          if (pos_y >= sy) begin
            pos_y = 0;
            pos_z = z + 1;
            if (pos_z >= sz) begin
              pos_z = 0;
              finished = 1;
            end
          end
        end else begin
          pos_x = x + 1;
        end
        if (!commit) continue;
        run_on = 0;
        ey = y + 1;
        while (ey < sy) begin
          full = 1;
          for (cx = bx; cx <= ex && full; cx++) if (!occupied(cx, ey, z)) full = 0;
          if (!full) break;
          ey++;
        end
        ey--;
        ez = z + 1;
        while (ez < sz) begin
          full = 1;
          for (cy = y; cy <= ey && full; cy++)
            for (cx = bx; cx <= ex && full; cx++) if (!occupied(cx, cy, ez)) full = 0;
          if (!full) break;
          ez++;
        end
        ez--;
        for (cz = z; cz <= ez; cz++)
          for (cy = y; cy <= ey; cy++)
            for (cx = bx; cx <= ex; cx++) vacate(cx, cy, cz);
        r.box_valid = 1'b1;
        r.start_x = bx[4:0];
        r.start_y = y[4:0];
        r.start_z = z[4:0];
        r.len_x = 6'(ex - bx + 1);
        r.len_y = 6'(ey - y + 1);
        r.len_z = 6'(ez - z + 1);
        pending.push_back(r);
        return;
      end
      r.done_res = 1'b1;
      pending.push_back(r);
    endfunction

    function void report(string msg);
      errors++;
      $display("mismatch at %0t: %s", $realtime, msg);
    endfunction

    function void check_result(res_t got);
      res_t want;
      if (pending.size() == 0) begin
        report($sformatf("unexpected result %h", got));
        return;
      end
      want = pending.pop_front();
      if (got.box_valid !== want.box_valid) report("box_valid");
      if (got.start_x !== want.start_x) report("start_x");
      if (got.start_y !== want.start_y) report("start_y");
      if (got.start_z !== want.start_z) report("start_z");
      if (got.len_x !== want.len_x) report("len_x");
      if (got.len_y !== want.len_y) report("len_y");
      if (got.len_z !== want.len_z) report("len_z");
      if (got.done_res !== want.done_res) report("done_res");
    endfunction
  endclass

  logic clk = 0;
  logic rst = 1;
  logic start = 0;
  cmd_t cmd = '0;
  logic busy;
  logic wr_en = 0;
  logic [1:0] wr_index = '0;
  logic [SIZE_W-1:0] wr_data = '0;
  logic result_valid;
  res_t result;

  box_scoreboard boxes = new();
  int sent = 0;

  greedy_voxel_box_merge_top u_top (
    .clk(clk), .rst(rst), .start(start), .cmd(cmd), .busy(busy),
    .wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data),
    .result_valid(result_valid), .result(result)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    if (!rst) begin
      if (result_valid) boxes.check_result(result);
      if (start && !busy) boxes.note_cmd(cmd);
    end
  end

  initial begin
    #200ms;
    $display("greedy_voxel_box_merge_top verification failed");
    $finish;
  end

  task automatic send(cmd_t c);
    start <= 1'b1;
    cmd <= c;
    do @(posedge clk); while (busy);
    sent++;
    if ($urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      if ($urandom_range(0, 9) == 0) repeat ($urandom_range(20, 80)) @(posedge clk);
      else repeat ($urandom_range(1, 3)) @(posedge clk);
    end
  endtask

  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (boxes.pending.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_size(logic [1:0] idx, logic [5:0] v);
    wr_en <= 1'b1;
    wr_index <= idx;
    wr_data <= v;
    @(posedge clk);
    boxes.set_size(idx, v);
    wr_en <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [63:0] pick_word();
    logic [63:0] a, b;
    a = {$urandom, $urandom};
    b = {$urandom, $urandom};
    case ($urandom_range(0, 5))
      0: return '1;
      1: return '0;
      2: return a;
      3: return a & b;
      4: return a | b;
      default: return a | b | {$urandom, $urandom};
    endcase
  endfunction

  task automatic load(int unsigned idx, logic [63:0] w);
    cmd_t c;
    c.func = FUNC_LOAD;
    c.word_index = idx[8:0];
    c.mask_word = w;
    send(c);
  endtask

  task automatic fetch();
    cmd_t c;
    c = {FUNC_FETCH, 9'($urandom), 64'({$urandom, $urandom})};
    send(c);
  endtask

  // fill: 0 random mix, 1 all set, 2 mostly clear
  task automatic run_phase(logic [5:0] rx, logic [5:0] ry, logic [5:0] rz,
                           int fill, int fetches);
    int unsigned words;
    drain();
    write_size(CFG_SIZE_X, rx);
    write_size(CFG_SIZE_Y, ry);
    write_size(CFG_SIZE_Z, rz);
    words = (boxes.clamp(rx) * boxes.clamp(ry) * boxes.clamp(rz) + 63) / 64;
    for (int unsigned w = 0; w < words; w++)
      load(w, fill == 1 ? '1 : fill == 2 ? ($urandom_range(0, 20) == 0 ? pick_word() : '0)
                         : pick_word());
    for (int i = 0; i < fetches; i++) begin
      if ($urandom_range(0, 19) == 0) load($urandom_range(0, words - 1), pick_word());
      else if ($urandom_range(0, 59) == 0) load($urandom_range(0, 511), pick_word());
      else fetch();
      if ($urandom_range(0, 49) == 0) drain();
    end
  endtask

  function automatic logic [5:0] pick_dim(int hi);
    case ($urandom_range(0, 9))
      0: return 6'd0;
      1: return 6'($urandom_range(32, 63));
      default: return 6'($urandom_range(1, hi));
    endcase
  endfunction

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    run_phase(6'd0, 6'd0, 6'd0, 1, 3);
    run_phase(6'd63, 6'd32, 6'd2, 1, 2);
    run_phase(6'd1, 6'd1, 6'd63, 1, 2);
    run_phase(6'd5, 6'd3, 6'd2, 0, 12);
    load(511, '1);
    run_phase(6'd32, 6'd32, 6'd32, 2, 12);
    while (sent < 1800) run_phase(pick_dim(12), pick_dim(12), pick_dim(4), 0,
                                  $urandom_range(5, 40));
    drain();
    if (boxes.errors == 0 && boxes.pending.size() == 0) begin
      $display("greedy_voxel_box_merge_top verification clean");
    end else begin
      $display("greedy_voxel_box_merge_top verification failed");
    end
    $finish;
  end
endmodule

// ===== filelist.f =====
rtl/gvbm_pkg.sv
rtl/gvbm_ram.sv
rtl/gvbm_addr.sv
rtl/gvbm_ctrl.sv
rtl/greedy_voxel_box_merge_top.sv
dv/tb_greedy_voxel_box_merge_top.sv
